// File: rtl/msc_pkg.sv
`timescale 1ns / 1ps

package msc_pkg;

    // Pattern registers hold this many bytes, whatever the window depth.
    localparam int REG_PATTERN_BYTES = 16;
    localparam int MIN_PATTERN       = 3;
    localparam int LEN_W             = 5;
    localparam int CFG_INDEX_W       = 8;
    localparam int CFG_DATA_W        = 64;
    localparam int OFFSET_OUT_W      = 32;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_PATTERN_LOW  = 8'd0;
    localparam cfg_index_t REG_PATTERN_HIGH = 8'd1;
    localparam cfg_index_t REG_CARE_MASK    = 8'd2;
    localparam cfg_index_t REG_LENGTH       = 8'd3;

    typedef enum logic [1:0] {
        OUTCOME_NOT_FOUND = 2'd0,
        OUTCOME_UNIQUE    = 2'd1,
        OUTCOME_MULTIPLE  = 2'd2
    } msc_outcome_t;

    // Pattern settings as seen by the compare logic; length is already clamped.
    typedef struct packed {
        logic [REG_PATTERN_BYTES-1:0][7:0] pattern;
        logic [REG_PATTERN_BYTES-1:0]      care;
        logic [LEN_W-1:0]                  length;
    } msc_cfg_t;

endpackage

// File: rtl/msc_if.sv
`timescale 1ns / 1ps

// Stream byte channel.
interface msc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// Scan report channel.
interface msc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  outcome;
    logic [31:0] match_offset;

    modport source (output valid, output outcome, output match_offset, input ready);
    modport sink (input valid, input outcome, input match_offset, output ready);
endinterface

// Configuration write channel.
interface msc_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/msc_cfg_regs.sv
`timescale 1ns / 1ps

module msc_cfg_regs #(
    parameter int WIN = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    msc_cfg_if.sink            cfg,
    output msc_pkg::msc_cfg_t  settings
);
    import msc_pkg::*;

    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic [15:0]           care_reg;
    logic [LEN_W-1:0]      length_reg;
    logic [LEN_W-1:0]      length_eff;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            care_reg         <= '0;
            length_reg       <= LEN_W'(MIN_PATTERN);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_PATTERN_LOW:  pattern_low_reg  <= cfg.data;
                REG_PATTERN_HIGH: pattern_high_reg <= cfg.data;
                REG_CARE_MASK:    care_reg         <= cfg.data[15:0];
                REG_LENGTH:       length_reg       <= cfg.data[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // Lengths below the minimum or beyond the window are clamped.
    always_comb
    begin
        if (length_reg < LEN_W'(MIN_PATTERN))
            length_eff = LEN_W'(MIN_PATTERN);
        else if (length_reg > LEN_W'(WIN))
            length_eff = LEN_W'(WIN);
        else
            length_eff = length_reg;
    end

    assign settings.pattern = {pattern_high_reg, pattern_low_reg};
    assign settings.care    = care_reg;
    assign settings.length  = length_eff;

endmodule

// File: rtl/msc_match.sv
`timescale 1ns / 1ps

module msc_match #(
    parameter int WIN = 16
) (
    input  logic [WIN-1:0][7:0] window,
    input  msc_pkg::msc_cfg_t   settings,
    output logic                hit
);
    import msc_pkg::*;

    localparam int IDX_W = $clog2(WIN);

    logic [WIN-1:0] miss;

    // Pattern byte k lines up with window entry length-1-k (entry 0 is newest).
    always_comb
    begin
        logic [LEN_W-1:0] pos;
        pos = '0;
        for (int k = 0; k < WIN; k++)
        begin
            pos = settings.length - LEN_W'(k) - LEN_W'(1);
            miss[k] = (LEN_W'(k) < settings.length) && settings.care[k] &&
                      (window[pos[IDX_W-1:0]] != settings.pattern[k]);
        end
    end

    assign hit = ~|miss;

endmodule

// File: rtl/masked_pattern_unique_scan.sv
`timescale 1ns / 1ps

// Masked pattern scanner with a uniqueness check. Bytes of a stream arrive one word at a
// time on scan; a pattern of 3 to 16 bytes with per-byte wildcards (care_mask clear) is
// compared against every alignment that ends on each new byte. On the word marked
// last_byte, one report word goes out: not found, a unique match with the offset of its
// first byte, or more than one match; the stream state then clears for the next stream.
// Throughput is one byte per clock cycle: the input register feeds a single masked compare
// over the sliding window, and the counters and report register update in that same cycle.
// A report turns valid as its last byte leaves the input register. Only a last byte can
// wait: it holds in the input register while the previous report has not been taken.
// Configuration registers are written through cfg and should change only between streams.

module masked_pattern_unique_scan #(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    msc_in_if.sink     scan,
    msc_out_if.source  report,
    msc_cfg_if.sink    cfg
);
    import msc_pkg::*;

    // The window never needs to be deeper than the pattern registers.
    localparam int WIN = (MAX_PATTERN < REG_PATTERN_BYTES) ? MAX_PATTERN : REG_PATTERN_BYTES;

    msc_cfg_t settings;

    // Input register.
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       s1_go;

    // Stream state.
    logic [WIN-1:0][7:0]    window_reg;
    logic [WIN-1:0][7:0]    window_next;
    logic [OFFSET_BITS-1:0] count_reg;
    logic [OFFSET_BITS-1:0] count_next;
    logic [1:0]             hits_reg;
    logic [1:0]             hits_next;
    logic [OFFSET_BITS-1:0] first_reg;
    logic [OFFSET_BITS-1:0] first_next;
    logic                   pattern_hit;
    logic                   hit;

    // Report register.
    logic                    out_valid_reg;
    msc_outcome_t            outcome_reg;
    msc_outcome_t            outcome_next;
    logic [OFFSET_OUT_W-1:0] offset_reg;
    logic [OFFSET_OUT_W-1:0] offset_next;
    logic [OFFSET_BITS+OFFSET_OUT_W-1:0] first_ext;

    msc_cfg_regs #(
        .WIN (WIN)
    ) u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .settings (settings)
    );

    // Ordinary bytes always move on; a last byte needs room in the report register.
    assign s1_go      = s1_valid_reg && (!s1_last_reg || !out_valid_reg || report.ready);
    assign scan.ready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (scan.ready)
            s1_valid_reg <= scan.valid;
    end

    always_ff @(posedge clk)
    begin
        if (scan.ready && scan.valid)
        begin
            s1_byte_reg <= scan.data_byte;
            s1_last_reg <= scan.last_byte;
        end
    end

    // The newest byte enters at entry 0 and older bytes move up one place.
    assign window_next = {window_reg[WIN-2:0], s1_byte_reg};

    msc_match #(
        .WIN (WIN)
    ) u_match (
        .window   (window_next),
        .settings (settings),
        .hit      (pattern_hit)
    );

    // The byte counter saturates; after that every byte is scored at the final position.
    assign count_next = (&count_reg) ? count_reg : count_reg + OFFSET_BITS'(1);
    assign hit        = pattern_hit && (count_next >= OFFSET_BITS'(settings.length));

    always_comb
    begin
        hits_next  = hits_reg;
        first_next = first_reg;
        if (hit)
        begin
            if (hits_reg == 2'd0)
                first_next = count_next - OFFSET_BITS'(settings.length);
            if (hits_reg != 2'd2)
                hits_next = hits_reg + 2'd1;
        end
    end

    assign first_ext = {{OFFSET_OUT_W{1'b0}}, first_next};

    always_comb
    begin
        case (hits_next)
            2'd0:
            begin
                outcome_next = OUTCOME_NOT_FOUND;
                offset_next  = '0;
            end
            2'd1:
            begin
                outcome_next = OUTCOME_UNIQUE;
                offset_next  = first_ext[OFFSET_OUT_W-1:0];
            end
            default:
            begin
                outcome_next = OUTCOME_MULTIPLE;
                offset_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            hits_reg  <= '0;
            first_reg <= '0;
        end
        else if (s1_go)
        begin
            if (s1_last_reg)
            begin
                count_reg <= '0;
                hits_reg  <= '0;
                first_reg <= '0;
            end
            else
            begin
                count_reg <= count_next;
                hits_reg  <= hits_next;
                first_reg <= first_next;
            end
        end
    end

    // Only entries written by the current stream are ever compared, so no clear is needed.
    always_ff @(posedge clk)
    begin
        if (s1_go)
            window_reg <= window_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_go && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (report.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
        begin
            outcome_reg <= outcome_next;
            offset_reg  <= offset_next;
        end
    end

    assign report.valid        = out_valid_reg;
    assign report.outcome      = outcome_reg;
    assign report.match_offset = offset_reg;

endmodule
